### rtl/fbpm_pkg.sv
// Package for the flash block pool manager: constants, codes, transaction types, helpers.
package fbpm_pkg;

  localparam int Banks         = 4;
  localparam int BlocksPerBank = 1024;
  localparam int PoolEntries   = 128;
  localparam int InitEmpty     = 100;

  localparam int KeyCount  = Banks * BlocksPerBank;
  localparam int KeyW      = $clog2(KeyCount);
  localparam int RowBits   = 64;
  localparam int BitW      = $clog2(RowBits);
  localparam int SetRows   = KeyCount / RowBits;
  localparam int RowW      = $clog2(SetRows);
  localparam int KindRows  = BlocksPerBank / RowBits;
  localparam int KindRowW  = $clog2(KindRows);
  localparam int SetWidth  = 3 * RowBits;
  localparam int KindWidth = 4 * RowBits;
  localparam int TallyW    = 13;
  localparam int TallyMax  = 4096;
  localparam int PoolW     = 8;

  localparam logic [3:0] KindNone  = 4'd0;
  localparam logic [3:0] KindUnset = 4'd15;

  typedef enum logic [2:0] {
    ACT_ADD_EMPTY   = 3'd0,
    ACT_ADD_DATA    = 3'd1,
    ACT_ADD_GARBAGE = 3'd2,
    ACT_DEL_EMPTY   = 3'd3,
    ACT_DEL_DATA    = 3'd4,
    ACT_DEL_GARBAGE = 3'd5,
    ACT_ALLOCATE    = 3'd6,
    ACT_QUERY       = 3'd7
  } action_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_POOL_FULL = 3'd3,
    ST_NO_EMPTY  = 3'd4
  } status_e;

  // Set indexes within one set memory row.
  typedef enum logic [1:0] {
    SET_EMPTY   = 2'd0,
    SET_DATA    = 2'd1,
    SET_GARBAGE = 2'd2
  } set_e;

  localparam logic [1:0] ReqWearLevel = 2'd3;

  typedef struct packed {
    logic [2:0] action;
    logic [1:0] bank;
    logic [9:0] block;
    logic [1:0] requester;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [1:0]        out_bank;
    logic [9:0]        out_block;
    logic [3:0]        block_kind;
    logic [TallyW-1:0] empty_count;
    logic [TallyW-1:0] data_count;
    logic [TallyW-1:0] garbage_count;
  } out_item_t;

  // Lowest set bit of a 64-bit word.
  function automatic logic [BitW-1:0] find_low(input logic [RowBits-1:0] v);
    logic [BitW-1:0] idx;
    idx = '0;
    for (int i = RowBits - 1; i >= 0; i--) begin
      if (v[i]) idx = BitW'(i);
    end
    return idx;
  endfunction

  // Highest set bit of a 64-bit word.
  function automatic logic [BitW-1:0] find_high(input logic [RowBits-1:0] v);
    logic [BitW-1:0] idx;
    idx = '0;
    for (int i = 0; i < RowBits; i++) begin
      if (v[i]) idx = BitW'(i);
    end
    return idx;
  endfunction

  // Set memory row after reset: empty bits for the first keys of bank zero.
  function automatic logic [SetWidth-1:0] init_set_row(input logic [RowW-1:0] r);
    logic [SetWidth-1:0] v;
    v = '0;
    for (int b = 0; b < RowBits; b++) begin
      if ((int'(r) * RowBits + b) < InitEmpty && (int'(r) * RowBits + b) < BlocksPerBank) begin
        v[b] = 1'b1;
      end
    end
    return v;
  endfunction

  // Kind memory row after reset.
  function automatic logic [KindWidth-1:0] init_kind_row(input logic [KindRowW-1:0] r);
    logic [KindWidth-1:0] v;
    v = '0;
    for (int j = 0; j < RowBits; j++) begin
      v[j*4 +: 4] = ((int'(r) * RowBits + j) < InitEmpty) ? KindNone : KindUnset;
    end
    return v;
  endfunction

  // Per-row summary of nonempty empty-set rows after reset.
  function automatic logic [SetRows-1:0] init_summary();
    logic [SetRows-1:0] v;
    v = '0;
    for (int r = 0; r < SetRows; r++) begin
      v[r] = (r * RowBits) < InitEmpty && (r * RowBits) < BlocksPerBank;
    end
    return v;
  endfunction

  function automatic logic [TallyW-1:0] tally_inc(input logic [TallyW-1:0] t);
    return (t < TallyW'(TallyMax)) ? t + TallyW'(1) : t;
  endfunction

  function automatic logic [TallyW-1:0] tally_dec(input logic [TallyW-1:0] t);
    return (t != '0) ? t - TallyW'(1) : t;
  endfunction

endpackage

### rtl/fbpm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fbpm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/flash_block_pool_manager.sv
// Top level of the flash block pool manager: sequencer, set and kind memories, tallies.
// Flow: an accepted transaction has its row read in the read state, then the execute state
// writes back and registers the result; a new transaction is taken only after execute completes.
// The execute cycle waits while the previous result is still held on the output.
// After reset a sweep of all set rows initializes both memories; input ready stays low meanwhile.
// Reset loads control state, tallies, pool usage and the per-row empty summary with initial values.
module flash_block_pool_manager (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fbpm_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output fbpm_pkg::out_item_t out_item_o
);
  import fbpm_pkg::*;

  typedef enum logic [3:0] {
    S_CLR  = 4'b0001,
    S_IDLE = 4'b0010,
    S_RD   = 4'b0100,
    S_EX   = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  logic [RowW-1:0]     clr_q, clr_d;
  in_item_t            item_q;
  logic [RowW-1:0]     row_q;
  logic [BitW-1:0]     bit_q;
  logic                have_q, in_range_q;
  logic [SetRows-1:0]  summary_q, summary_d;
  logic [TallyW-1:0]   tally_q [3];
  logic [TallyW-1:0]   tally_d [3];
  logic [PoolW-1:0]    pool_q, pool_d;
  logic                out_valid_q;
  out_item_t           out_q, out_d;

  logic [SetWidth-1:0]  set_rdata, set_wdata;
  logic [KindWidth-1:0] kind_rdata, kind_wdata;
  logic                 set_we, kind_we;
  logic [RowW-1:0]      set_waddr;
  logic [KindRowW-1:0]  kind_waddr;

  logic                 accept, load;
  logic [KeyW-1:0]      in_key;
  logic [RowW-1:0]      alloc_row;
  logic                 in_range;

  logic [2:0][RowBits-1:0] sets_n;
  logic [KindWidth-1:0]    kind_n;
  logic [BitW-1:0]         fb;
  logic [1:0]              dst, src;
  logic [2:0]              st;
  logic [1:0]              ob;
  logic [9:0]              oblk;
  logic [3:0]              kind;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign load        = (state_q == S_EX) && (!out_valid_q || out_ready_i);

  // Key and row selection at accept time; allocation searches the summary.
  assign in_key    = {in_item_i.bank, in_item_i.block};
  assign in_range  = (int'(in_item_i.bank) < Banks) && (int'(in_item_i.block) < BlocksPerBank);
  assign alloc_row = (in_item_i.requester == ReqWearLevel) ? RowW'(find_high(summary_q))
                                                           : RowW'(find_low(summary_q));

  // Memories: set bitmaps (empty, data, garbage per row) and block kind tags.
  fbpm_ram #(.Width(SetWidth), .Depth(SetRows)) u_set_ram (
    .clk_i   (clk_i),
    .we_i    (set_we),
    .waddr_i (set_waddr),
    .wdata_i (set_wdata),
    .raddr_i (row_q),
    .rdata_o (set_rdata)
  );

  fbpm_ram #(.Width(KindWidth), .Depth(KindRows)) u_kind_ram (
    .clk_i   (clk_i),
    .we_i    (kind_we),
    .waddr_i (kind_waddr),
    .wdata_i (kind_wdata),
    .raddr_i (row_q[KindRowW-1:0]),
    .rdata_o (kind_rdata)
  );

  // Execute: decide the outcome from the row just read and build the write back.
  always_comb begin
    sets_n = set_rdata;
    kind_n = kind_rdata;
    for (int i = 0; i < 3; i++) tally_d[i] = tally_q[i];
    pool_d = pool_q;
    st     = ST_OK;
    ob     = '0;
    oblk   = '0;
    kind   = '0;
    dst    = SET_EMPTY;
    src    = SET_GARBAGE;
    fb     = (item_q.requester == ReqWearLevel) ? find_high(set_rdata[RowBits-1:0])
                                                : find_low(set_rdata[RowBits-1:0]);
    if (item_q.action == ACT_ALLOCATE) begin
      if (!have_q) begin
        st = ST_NO_EMPTY;
      end else if (sets_n[SET_DATA][fb]) begin
        st = ST_DUPLICATE;
      end else begin
        sets_n[SET_EMPTY][fb] = 1'b0;
        sets_n[SET_DATA][fb]  = 1'b1;
        tally_d[SET_EMPTY]    = tally_dec(tally_q[SET_EMPTY]);
        tally_d[SET_DATA]     = tally_inc(tally_q[SET_DATA]);
        ob   = row_q[RowW-1:KindRowW];
        oblk = {row_q[KindRowW-1:0], fb};
        kind = {2'b00, item_q.requester} + 4'd1;
        kind_n[fb*4 +: 4] = kind;
      end
    end else if (!in_range_q) begin
      st = ST_NOT_FOUND;
    end else begin
      case (item_q.action)
        ACT_ADD_EMPTY, ACT_ADD_DATA, ACT_ADD_GARBAGE: begin
          case (item_q.action)
            ACT_ADD_EMPTY: begin
              dst = SET_EMPTY;
              src = SET_GARBAGE;
            end
            ACT_ADD_DATA: begin
              dst = SET_DATA;
              src = SET_EMPTY;
            end
            default: begin
              dst = SET_GARBAGE;
              src = SET_DATA;
            end
          endcase
          if (sets_n[dst][bit_q]) begin
            st = ST_DUPLICATE;
          end else if (!sets_n[src][bit_q] && int'(pool_q) >= PoolEntries) begin
            st = ST_POOL_FULL;
          end else begin
            if (sets_n[src][bit_q]) begin
              sets_n[src][bit_q] = 1'b0;
              tally_d[src] = tally_dec(tally_q[src]);
            end else begin
              pool_d = pool_q + PoolW'(1);
            end
            sets_n[dst][bit_q] = 1'b1;
            tally_d[dst] = tally_inc(tally_q[dst]);
            if (item_q.action == ACT_ADD_EMPTY) kind_n[bit_q*4 +: 4] = KindNone;
          end
        end
        ACT_DEL_EMPTY, ACT_DEL_DATA, ACT_DEL_GARBAGE: begin
          dst = 2'(item_q.action - ACT_DEL_EMPTY);
          if (!sets_n[dst][bit_q]) begin
            st = ST_NOT_FOUND;
          end else begin
            sets_n[dst][bit_q] = 1'b0;
            if (pool_q != '0) pool_d = pool_q - PoolW'(1);
          end
        end
        default: begin
          kind = kind_rdata[bit_q*4 +: 4];
        end
      endcase
    end
    out_d.status        = st;
    out_d.out_bank      = ob;
    out_d.out_block     = oblk;
    out_d.block_kind    = kind;
    out_d.empty_count   = tally_d[SET_EMPTY];
    out_d.data_count    = tally_d[SET_DATA];
    out_d.garbage_count = tally_d[SET_GARBAGE];
  end

  // Memory write ports: initialization sweep or execute write back.
  always_comb begin
    if (state_q == S_CLR) begin
      set_we     = 1'b1;
      set_waddr  = clr_q;
      set_wdata  = init_set_row(clr_q);
      kind_we    = int'(clr_q) < KindRows;
      kind_waddr = clr_q[KindRowW-1:0];
      kind_wdata = init_kind_row(clr_q[KindRowW-1:0]);
    end else begin
      set_we     = load;
      set_waddr  = row_q;
      set_wdata  = sets_n;
      kind_we    = load;
      kind_waddr = row_q[KindRowW-1:0];
      kind_wdata = kind_n;
    end
  end

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    summary_d = summary_q;
    unique case (state_q)
      S_CLR: begin
        clr_d = clr_q + RowW'(1);
        if (clr_q == RowW'(SetRows - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_d = S_RD;
      end
      S_RD: begin
        state_d = S_EX;
      end
      S_EX: begin
        if (load) begin
          state_d = S_IDLE;
          summary_d[row_q] = |sets_n[SET_EMPTY];
        end
      end
      default: state_d = S_CLR;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      summary_q   <= init_summary();
      tally_q[SET_EMPTY]   <= TallyW'(InitEmpty);
      tally_q[SET_DATA]    <= '0;
      tally_q[SET_GARBAGE] <= '0;
      pool_q      <= PoolW'(InitEmpty);
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      summary_q <= summary_d;
      if (load) begin
        for (int i = 0; i < 3; i++) tally_q[i] <= tally_d[i];
        pool_q      <= pool_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q     <= in_item_i;
      in_range_q <= in_range;
      have_q     <= |summary_q;
      row_q      <= (in_item_i.action == ACT_ALLOCATE) ? alloc_row : in_key[KeyW-1:BitW];
      bit_q      <= in_key[BitW-1:0];
    end
    if (load) begin
      out_q <= out_d;
    end
  end

  // Checks on the sequencer and the counters.
  a_accept_reads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_RD) else $error("accepted transaction did not start a read");
  a_load_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (state_q == S_IDLE && out_valid_q)) else $error("execute did not complete");
  a_pool_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(pool_q) <= PoolEntries) else $error("pool usage above capacity");
  a_tally_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(tally_q[SET_EMPTY]) <= TallyMax && int'(tally_q[SET_DATA]) <= TallyMax &&
    int'(tally_q[SET_GARBAGE]) <= TallyMax) else $error("tally above saturation limit");

endmodule

### tb/tb_top.sv
// Testbench for the flash block pool manager: directed table, random traffic, scoreboard.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import fbpm_pkg::*;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  in_item_t in_item_i;
  out_item_t out_item_o;

  flash_block_pool_manager dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_item_o(out_item_o)
  );

  // Shadow copy of the block sets, kind table, pool usage and tallies.
  bit sh_empty[KeyCount];
  bit sh_data[KeyCount];
  bit sh_garbage[KeyCount];
  logic [3:0] sh_kind[BlocksPerBank];
  int unsigned sh_pool;
  logic [TallyW-1:0] sh_empty_n, sh_data_n, sh_garbage_n;

  out_item_t expected_results[$];
  int errors = 0;
  bit long_hold = 0;

  // Directed rows; a check flag marks rows whose outcome is typed in.
  typedef struct {
    action_e act;
    logic [1:0] bank;
    logic [9:0] blk;
    logic [1:0] req;
    bit check;
    status_e st;
  } row_t;

  row_t directed_rows[$];

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("flash_block_pool_manager test failed");
    $finish;
  end

  function automatic logic [TallyW-1:0] tally_up(logic [TallyW-1:0] t);
    return (t < TallyW'(TallyMax)) ? t + 1'b1 : t;
  endfunction

  function automatic logic [TallyW-1:0] tally_dn(logic [TallyW-1:0] t);
    return (t != 0) ? t - 1'b1 : t;
  endfunction

  // Add to set dst (0 empty, 1 data, 2 garbage); the leaving set is the one before it.
  function automatic status_e move_in(int dst, int key);
    bit in_dst, in_src;
    in_dst = (dst == 0) ? sh_empty[key] : (dst == 1) ? sh_data[key] : sh_garbage[key];
    in_src = (dst == 0) ? sh_garbage[key] : (dst == 1) ? sh_empty[key] : sh_data[key];
    if (in_dst) return ST_DUPLICATE;
    if (in_src) begin
      case (dst)
        0: begin sh_garbage[key] = 0; sh_garbage_n = tally_dn(sh_garbage_n); end
        1: begin sh_empty[key] = 0; sh_empty_n = tally_dn(sh_empty_n); end
        default: begin sh_data[key] = 0; sh_data_n = tally_dn(sh_data_n); end
      endcase
    end else begin
      if (sh_pool >= PoolEntries) return ST_POOL_FULL;
      sh_pool++;
    end
    case (dst)
      0: begin sh_empty[key] = 1; sh_empty_n = tally_up(sh_empty_n); end
      1: begin sh_data[key] = 1; sh_data_n = tally_up(sh_data_n); end
      default: begin sh_garbage[key] = 1; sh_garbage_n = tally_up(sh_garbage_n); end
    endcase
    return ST_OK;
  endfunction

  // Predict one result and update the shadow state.
  function automatic out_item_t predict_pool_step(in_item_t it);
    out_item_t r;
    int key, found;
    bit have;
    r = '0;
    r.status = ST_OK;
    key = int'(it.bank) * BlocksPerBank + int'(it.block);
    if (it.action == ACT_ALLOCATE) begin
      have = 0;
      found = 0;
      if (it.requester == ReqWearLevel) begin
        for (int i = KeyCount - 1; i >= 0; i--)
          if (!have && sh_empty[i]) begin have = 1; found = i; end
      end else begin
        for (int i = 0; i < KeyCount; i++)
          if (!have && sh_empty[i]) begin have = 1; found = i; end
      end
      if (!have) r.status = ST_NO_EMPTY;
      else if (sh_data[found]) r.status = ST_DUPLICATE;
      else begin
        sh_empty[found] = 0;
        sh_empty_n = tally_dn(sh_empty_n);
        sh_data[found] = 1;
        sh_data_n = tally_up(sh_data_n);
        r.out_bank = 2'(found / BlocksPerBank);
        r.out_block = 10'(found % BlocksPerBank);
        r.block_kind = 4'(it.requester) + 4'd1;
        sh_kind[r.out_block] = r.block_kind;
      end
    end else begin
      case (it.action)
        ACT_ADD_EMPTY: begin
          r.status = move_in(0, key);
          if (r.status == ST_OK) sh_kind[it.block] = KindNone;
        end
        ACT_ADD_DATA: r.status = move_in(1, key);
        ACT_ADD_GARBAGE: r.status = move_in(2, key);
        ACT_DEL_EMPTY, ACT_DEL_DATA, ACT_DEL_GARBAGE: begin
          bit present;
          present = (it.action == ACT_DEL_EMPTY) ? sh_empty[key] :
                    (it.action == ACT_DEL_DATA) ? sh_data[key] : sh_garbage[key];
          if (!present) r.status = ST_NOT_FOUND;
          else begin
            if (it.action == ACT_DEL_EMPTY) sh_empty[key] = 0;
            else if (it.action == ACT_DEL_DATA) sh_data[key] = 0;
            else sh_garbage[key] = 0;
            if (sh_pool > 0) sh_pool--;
          end
        end
        default: r.block_kind = sh_kind[it.block];
      endcase
    end
    r.empty_count = sh_empty_n;
    r.data_count = sh_data_n;
    r.garbage_count = sh_garbage_n;
    return r;
  endfunction

  // Offer one transaction, holding it until accepted, with a random gap first.
  task automatic send_request(in_item_t it, int gap);
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_results.push_back(predict_pool_step(it));
  endtask

  // Random item biased toward live keys so moves, deletes and duplicates occur.
  function automatic in_item_t random_request();
    in_item_t it;
    int pick;
    it.action = 3'($urandom_range(7));
    it.requester = 2'($urandom_range(3));
    pick = $urandom_range(99);
    if (pick < 60) begin
      it.bank = 2'($urandom_range(1));
      it.block = 10'($urandom_range(127));
    end else if (pick < 75) begin
      it.bank = 2'd3;
      it.block = 10'($urandom_range(1023, 1000));
    end else begin
      it.bank = 2'($urandom_range(3));
      it.block = 10'($urandom_range(1023));
    end
    return it;
  endfunction

  // Receiver: random stall pattern plus one long hold-off.
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold) out_ready_i <= 1'b0;
      else out_ready_i <= ($urandom_range(3) != 0);
    end
  end

  initial begin
    long_hold = 0;
    wait (rst_ni);
    repeat (400) @(posedge clk_i);
    long_hold = 1;
    repeat (300) @(posedge clk_i);
    long_hold = 0;
  end

  // Checker: compare every accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", out_item_o);
      end else begin
        out_item_t e;
        e = expected_results.pop_front();
        if (out_item_o !== e) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p, got %p", e, out_item_o);
        end
      end
    end
  end

  initial begin
    in_item_t it;
    int burst, wait_cycles;
    in_valid_i = 1'b0;
    in_item_i = '0;
    rst_ni = 1'b0;
    for (int i = 0; i < KeyCount; i++) begin
      sh_empty[i] = (i < InitEmpty);
      sh_data[i] = 0;
      sh_garbage[i] = 0;
    end
    for (int i = 0; i < BlocksPerBank; i++) sh_kind[i] = (i < InitEmpty) ? KindNone : KindUnset;
    sh_pool = InitEmpty;
    sh_empty_n = TallyW'(InitEmpty);
    sh_data_n = '0;
    sh_garbage_n = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows: queries after reset, every action, extremes and error codes.
    directed_rows = '{
      '{ACT_QUERY, 2'd0, 10'd0, 2'd0, 1, ST_OK},
      '{ACT_QUERY, 2'd3, 10'd1023, 2'd3, 1, ST_OK},
      '{ACT_DEL_DATA, 2'd0, 10'd5, 2'd0, 1, ST_NOT_FOUND},
      '{ACT_DEL_GARBAGE, 2'd3, 10'd1023, 2'd0, 1, ST_NOT_FOUND},
      '{ACT_ADD_EMPTY, 2'd0, 10'd0, 2'd0, 1, ST_DUPLICATE},
      '{ACT_ALLOCATE, 2'd0, 10'd0, 2'd0, 0, ST_OK},
      '{ACT_ALLOCATE, 2'd0, 10'd0, 2'd3, 0, ST_OK},
      '{ACT_ALLOCATE, 2'd2, 10'd7, 2'd1, 0, ST_OK},
      '{ACT_ALLOCATE, 2'd1, 10'd9, 2'd2, 0, ST_OK},
      '{ACT_QUERY, 2'd1, 10'd0, 2'd0, 0, ST_OK},
      '{ACT_ADD_GARBAGE, 2'd0, 10'd0, 2'd0, 0, ST_OK},
      '{ACT_ADD_EMPTY, 2'd0, 10'd0, 2'd0, 0, ST_OK},
      '{ACT_ADD_DATA, 2'd3, 10'd1023, 2'd0, 0, ST_OK},
      '{ACT_ADD_EMPTY, 2'd3, 10'd1023, 2'd0, 0, ST_OK},
      '{ACT_ALLOCATE, 2'd0, 10'd0, 2'd3, 0, ST_OK},
      '{ACT_DEL_EMPTY, 2'd0, 10'd50, 2'd0, 0, ST_OK},
      '{ACT_DEL_DATA, 2'd0, 10'd1, 2'd0, 0, ST_OK},
      '{ACT_ADD_GARBAGE, 2'd2, 10'd512, 2'd0, 0, ST_OK},
      '{ACT_DEL_GARBAGE, 2'd2, 10'd512, 2'd0, 0, ST_OK}
    };
    foreach (directed_rows[i]) begin
      it.action = directed_rows[i].act;
      it.bank = directed_rows[i].bank;
      it.block = directed_rows[i].blk;
      it.requester = directed_rows[i].req;
      send_request(it, 0);
      if (directed_rows[i].check && expected_results[$].status != directed_rows[i].st) begin
        errors++;
        if (errors <= 10) $display("row %0d: status %0d, table says %0d", i,
                                   expected_results[$].status, directed_rows[i].st);
      end
    end

    // Fill the pool to exhaustion with fresh keys, then drain it.
    for (int i = 0; i < 40; i++) begin
      it.action = ACT_ADD_GARBAGE;
      it.bank = 2'd1;
      it.block = 10'(600 + i);
      it.requester = 2'd0;
      send_request(it, 0);
    end
    for (int i = 0; i < 40; i++) begin
      it.action = ACT_DEL_GARBAGE;
      it.bank = 2'd1;
      it.block = 10'(600 + i);
      it.requester = 2'd0;
      send_request(it, 0);
    end

    // Random bursts; an allocation storm now and then empties the empty set.
    burst = 0;
    for (int n = 0; n < 1250; n++) begin
      if (burst == 0) begin
        burst = $urandom_range(20, 1);
        wait_cycles = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
      end else wait_cycles = 0;
      burst--;
      it = random_request();
      if ((n % 300) > 200 && (n % 300) < 260) it.action = ACT_ALLOCATE;
      send_request(it, wait_cycles);
    end
    in_valid_i <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) $display("flash_block_pool_manager test passed");
    else $display("flash_block_pool_manager test failed");
    $finish;
  end
endmodule
